@@ hdl/cylinder_point_test_and_project_core_defines.svh @@
// assertion macros used by the checker file
`ifndef CYLINDER_POINT_TEST_AND_PROJECT_CORE_DEFINES_SVH
`define CYLINDER_POINT_TEST_AND_PROJECT_CORE_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define CPT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("cpt assertion failed");

// clocked assertion that also holds during reset
`define CPT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("cpt assertion failed");

`endif

@@ hdl/cpt_pkg.sv @@
// shared widths, register codes and pipeline sideband types
`timescale 1ns / 1ps
package cpt_pkg;
  localparam int unsigned CoordW      = 32;
  localparam int unsigned LenW        = 31;
  localparam int unsigned SqW         = 64;
  localparam int unsigned RootW       = 32;
  localparam int unsigned QuoW        = 31;
  localparam int unsigned ProdW       = 62;
  localparam int unsigned SqrtStages  = SqW / 2;
  localparam int unsigned DivStages   = QuoW;
  localparam int unsigned PreStages   = 3;
  localparam int unsigned Latency     = PreStages + SqrtStages + 1 + DivStages;
  localparam int unsigned AddrW       = 3;

  // register index codes
  localparam logic REG_HALF_LENGTH = 1'b0;
  localparam logic REG_RADIUS      = 1'b1;

  // sideband carried alongside the square root
  typedef struct packed {
    logic              in_pt;
    logic              in_all;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] ay;
    logic [CoordW-1:0] az;
    logic              sy;
    logic              sz;
  } root_side_t;

  // sideband carried alongside the dividers
  typedef struct packed {
    logic              in_pt;
    logic              in_all;
    logic [CoordW-1:0] px;
    logic              sy;
    logic              sz;
    logic              zero;
  } div_side_t;
endpackage

@@ hdl/cpt_if.sv @@
// point and result channel interfaces
`timescale 1ns / 1ps
interface cpt_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic        [30:0] object_radius;
  modport source (output valid, pos_x, pos_y, pos_z, object_radius, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, object_radius, output ready);
endinterface

interface cpt_out_if;
  logic               valid;
  logic               ready;
  logic               is_inside;
  logic               all_inside;
  logic signed [31:0] proj_x;
  logic signed [31:0] proj_y;
  logic signed [31:0] proj_z;
  modport source (output valid, is_inside, all_inside, proj_x, proj_y, proj_z, input ready);
  modport sink (input valid, is_inside, all_inside, proj_x, proj_y, proj_z, output ready);
endinterface

@@ hdl/cylinder_point_test_and_project_core.sv @@
// cylinder point test and surface projection, top level
// Usage: points enter on in_if (valid/ready), one transfer per point with
// pos_x, pos_y, pos_z and object_radius. Each point yields exactly one
// transfer on out_if with is_inside, all_inside and the projected point.
// half_length and radius are written over the APB port (byte address 0 and
// 4); write them only while no point is in flight (not enforced by the block).
// The pipeline holds stages a, b and c (abs, squares and compares), 32
// square-root stages (two radicand bits each), the radius-product register
// and 31 divider stages (one quotient bit each).
// Throughput is one point per cycle without stalls; every stage is a register,
// valid bits travel with the data and the whole pipeline moves as one.
// When the receiver stalls with a result waiting, the pipeline freezes and
// in_if.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and both registers to zero; no clearing
// pass is needed.
`timescale 1ns / 1ps
module cylinder_point_test_and_project_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cpt_in_if.sink                      in_if,
  cpt_out_if.source                   out_if,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpt_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import cpt_pkg::*;

  // configuration registers
  logic [LenW-1:0] hl_q, rad_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hl_q  <= '0;
      rad_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_HALF_LENGTH: hl_q  <= pwdata[LenW-1:0];
        REG_RADIUS:      rad_q <= pwdata[LenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HALF_LENGTH: prdata = {1'b0, hl_q};
      REG_RADIUS:      prdata = {1'b0, rad_q};
      default:         prdata = '0;
    endcase
  end

  // pipeline advance and valid line
  logic en;
  logic vld_q [Latency];

  assign en          = !vld_q[Latency-1] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Latency; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_if.valid;
      for (int k = 1; k < Latency; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // stage a: magnitudes and signs
  logic signed [CoordW-1:0] xa_q;
  logic [CoordW-1:0]        axa_q, aya_q, aza_q;
  logic                     sya_q, sza_q;
  logic [LenW-1:0]          orad_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      xa_q     <= in_if.pos_x;
      axa_q    <= in_if.pos_x[CoordW-1] ? CoordW'(-in_if.pos_x) : in_if.pos_x;
      aya_q    <= in_if.pos_y[CoordW-1] ? CoordW'(-in_if.pos_y) : in_if.pos_y;
      aza_q    <= in_if.pos_z[CoordW-1] ? CoordW'(-in_if.pos_z) : in_if.pos_z;
      sya_q    <= in_if.pos_y[CoordW-1];
      sza_q    <= in_if.pos_z[CoordW-1];
      orad_a_q <= in_if.object_radius;
    end
  end

  // stage b: squares, axial tests and clamp
  logic [SqW-1:0]    yy_b_q, zz_b_q;
  logic [ProdW-1:0]  rr_b_q, dd_b_q;
  logic              xin_b_q, okall_b_q;
  logic [CoordW-1:0] px_b_q, ay_b_q, az_b_q;
  logic              sy_b_q, sz_b_q;
  logic [LenW-1:0]   dif_b;
  logic [LenW:0]     xsum_b;
  logic signed [CoordW-1:0] hl_s;

  assign dif_b  = rad_q - orad_a_q;
  assign xsum_b = axa_q[LenW:0] + {1'b0, orad_a_q};
  assign hl_s   = {1'b0, hl_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      yy_b_q    <= aya_q * aya_q;
      zz_b_q    <= aza_q * aza_q;
      rr_b_q    <= rad_q * rad_q;
      dd_b_q    <= dif_b * dif_b;
      xin_b_q   <= axa_q <= {1'b0, hl_q};
      okall_b_q <= (orad_a_q <= rad_q) && !axa_q[CoordW-1]
                   && (xsum_b <= {1'b0, hl_q});
      if (xa_q > hl_s) px_b_q <= hl_s;
      else if (xa_q < -hl_s) px_b_q <= -hl_s;
      else px_b_q <= xa_q;
      ay_b_q <= aya_q;
      az_b_q <= aza_q;
      sy_b_q <= sya_q;
      sz_b_q <= sza_q;
    end
  end

  // stage c: radial sum and compares
  logic [SqW-1:0] rt_c, rt_c_q;
  root_side_t     side_c_q;

  assign rt_c = yy_b_q + zz_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_c_q          <= rt_c;
      side_c_q.in_pt  <= xin_b_q && (rt_c <= {2'b0, rr_b_q});
      side_c_q.in_all <= okall_b_q && (rt_c <= {2'b0, dd_b_q});
      side_c_q.px     <= px_b_q;
      side_c_q.ay     <= ay_b_q;
      side_c_q.az     <= az_b_q;
      side_c_q.sy     <= sy_b_q;
      side_c_q.sz     <= sz_b_q;
    end
  end

  // square root of the radial sum
  logic [RootW-1:0] norm;
  root_side_t       rside_q [SqrtStages];

  cpt_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rt_c_q),
    .root_o (norm)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      rside_q[0] <= side_c_q;
      for (int k = 1; k < SqrtStages; k++) rside_q[k] <= rside_q[k-1];
    end
  end

  // radius products for the two dividers
  logic [ProdW:0]   ny_full, nz_full;
  logic [ProdW-1:0] ny_q, nz_q;
  logic [RootW-1:0] norm_q;
  div_side_t        side_m_q;

  assign ny_full = rad_q * rside_q[SqrtStages-1].ay;
  assign nz_full = rad_q * rside_q[SqrtStages-1].az;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ny_q            <= ny_full[ProdW-1:0];
      nz_q            <= nz_full[ProdW-1:0];
      norm_q          <= norm;
      side_m_q.in_pt  <= rside_q[SqrtStages-1].in_pt;
      side_m_q.in_all <= rside_q[SqrtStages-1].in_all;
      side_m_q.px     <= rside_q[SqrtStages-1].px;
      side_m_q.sy     <= rside_q[SqrtStages-1].sy;
      side_m_q.sz     <= rside_q[SqrtStages-1].sz;
      side_m_q.zero   <= norm == '0;
    end
  end

  // dividers
  logic [QuoW-1:0] qy, qz;
  div_side_t       dside_q [DivStages];

  cpt_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (ny_q),
    .den_i (norm_q),
    .quo_o (qy)
  );

  cpt_div u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (nz_q),
    .den_i (norm_q),
    .quo_o (qz)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      dside_q[0] <= side_m_q;
      for (int k = 1; k < DivStages; k++) dside_q[k] <= dside_q[k-1];
    end
  end

  // result transfer
  div_side_t side_o;
  assign side_o = dside_q[DivStages-1];

  assign out_if.valid      = vld_q[Latency-1];
  assign out_if.is_inside  = side_o.in_pt;
  assign out_if.all_inside = side_o.in_all;
  assign out_if.proj_x     = side_o.px;

  always_comb begin
    if (side_o.zero) begin
      out_if.proj_y = {1'b0, rad_q};
      out_if.proj_z = '0;
    end else begin
      out_if.proj_y = side_o.sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      out_if.proj_z = side_o.sz ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
    end
  end
endmodule

@@ hdl/cpt_sqrt.sv @@
// pipelined integer square root, two radicand bits per stage
`timescale 1ns / 1ps
module cpt_sqrt (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cpt_pkg::SqW-1:0]    rad_i,
  output logic [cpt_pkg::RootW-1:0]  root_o
);
  import cpt_pkg::*;

  logic [SqW-1:0]   val_q  [SqrtStages];
  logic [RootW+1:0] rem_q  [SqrtStages];
  logic [RootW-1:0] root_q [SqrtStages];

  for (genvar i = 0; i < SqrtStages; i++) begin : g_stage
    logic [SqW-1:0]   val_in;
    logic [RootW+1:0] rem_in;
    logic [RootW-1:0] root_in;
    logic [RootW+1:0] rem_sh;
    logic [RootW+1:0] trial;

    if (i == 0) begin : g_first
      assign val_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign val_in  = val_q[i-1];
      assign rem_in  = rem_q[i-1];
      assign root_in = root_q[i-1];
    end

    // bring down two bits and try the next root bit
    assign rem_sh = {rem_in[RootW-1:0], val_in[SqW-1 -: 2]};
    assign trial  = {root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[i] <= val_in << 2;
        if (rem_sh >= trial) begin
          rem_q[i]  <= rem_sh - trial;
          root_q[i] <= {root_in[RootW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= rem_sh;
          root_q[i] <= {root_in[RootW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[SqrtStages-1];
endmodule

@@ hdl/cpt_div.sv @@
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module cpt_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cpt_pkg::ProdW-1:0]  num_i,
  input  logic [cpt_pkg::RootW-1:0]  den_i,
  output logic [cpt_pkg::QuoW-1:0]   quo_o
);
  import cpt_pkg::*;

  logic [RootW-1:0] rem_q  [DivStages];
  logic [QuoW-1:0]  bits_q [DivStages];
  logic [RootW-1:0] den_q  [DivStages];
  logic [QuoW-1:0]  quo_q  [DivStages];

  for (genvar j = 0; j < DivStages; j++) begin : g_stage
    logic [RootW-1:0] rem_in;
    logic [QuoW-1:0]  bits_in;
    logic [RootW-1:0] den_in;
    logic [QuoW-1:0]  quo_in;
    logic [RootW:0]   trial;
    logic [RootW:0]   diff;

    if (j == 0) begin : g_first
      // upper numerator part is below the divisor since the quotient fits
      assign rem_in  = {1'b0, num_i[ProdW-1 -: QuoW]};
      assign bits_in = num_i[QuoW-1:0];
      assign den_in  = den_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign bits_in = bits_q[j-1];
      assign den_in  = den_q[j-1];
      assign quo_in  = quo_q[j-1];
    end

    assign trial = {rem_in, bits_in[QuoW-1]};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        bits_q[j] <= bits_in << 1;
        den_q[j]  <= den_in;
        if (trial >= {1'b0, den_in}) begin
          rem_q[j] <= diff[RootW-1:0];
          quo_q[j] <= {quo_in[QuoW-2:0], 1'b1};
        end else begin
          rem_q[j] <= trial[RootW-1:0];
          quo_q[j] <= {quo_in[QuoW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];
endmodule

@@ hdl/cpt_checker.sv @@
// port-level checker for the cylinder core, bound to the top level
`timescale 1ns / 1ps
`include "cylinder_point_test_and_project_core_defines.svh"
module cpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        is_inside_i,
  input logic        all_inside_i,
  input logic [31:0] proj_x_i,
  input logic [31:0] proj_y_i,
  input logic [31:0] proj_z_i
);
  // a stalled result stays offered
  `CPT_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i)

  // a stalled result keeps its payload
  `CPT_ASSERT(a_out_stable, clk_i, rst_ni,
              out_valid_i && !out_ready_i |=> $stable(proj_x_i) && $stable(proj_y_i)
              && $stable(proj_z_i) && $stable(is_inside_i) && $stable(all_inside_i))

  // a sphere wholly inside means its center is inside
  `CPT_ASSERT(a_all_implies_in, clk_i, rst_ni, out_valid_i && all_inside_i |-> is_inside_i)

  // input is taken whenever the output side can move
  `CPT_ASSERT_ALWAYS(a_ready_link, clk_i, in_ready_i == (!out_valid_i || out_ready_i))

  // an input transfer only happens while the output side is free to move
  `CPT_ASSERT(a_flow, clk_i, rst_ni, in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
endmodule

bind cylinder_point_test_and_project_core cpt_checker u_cpt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .is_inside_i  (out_if.is_inside),
  .all_inside_i (out_if.all_inside),
  .proj_x_i     (out_if.proj_x),
  .proj_y_i     (out_if.proj_y),
  .proj_z_i     (out_if.proj_z)
);
